FILE: rtl/core/tws_pkg.sv
// Shared types and constants of the timing wheel task scheduler.
// Used by the front, queue, back and top level modules and by the checker.
package tws_pkg;

    // Default configuration
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_WHEEL_SLOTS = 1000;

    // Field widths
    localparam int FIELD_W  = 16;
    localparam int TARGET_W = 8;
    localparam int ID_W     = 4;
    localparam int MS_W     = 32;
    localparam int TICK_W   = 10;
    localparam int RUN_W    = 8;

    localparam logic [RUN_W-1:0] RUN_MAX     = '1;
    localparam logic [MS_W-1:0]  MS_PER_TICK = 32'd10;

    // Dispatch emits at most this many entries per item
    localparam int RESULT_CAP = 16;
    localparam int EMIT_W     = $clog2(RESULT_CAP);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Classified command handed from front to back
    typedef struct packed {
        t_op                 op;
        logic [TICK_W-1:0]   delay_mod;
        logic [TICK_W-1:0]   reload;
        logic                periodic;
        logic [TARGET_W-1:0] target;
    } t_cmd;

    // One row of the task table
    typedef struct packed {
        logic [TICK_W-1:0] remain;
        logic [TICK_W-1:0] reload;
        logic              periodic;
        logic [RUN_W-1:0]  runs;
    } t_entry;

endpackage

FILE: rtl/core/tws_front.sv
// Front end: accepts items, reduces add delays and periods modulo the wheel size.
// Depends on tws_pkg; feeds tws_queue.
module tws_front #(
    parameter int WHEEL_SLOTS = tws_pkg::DEF_WHEEL_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [tws_pkg::FIELD_W-1:0]   i_first_delay,
    input  logic [tws_pkg::FIELD_W-1:0]   i_repeat_period,
    input  logic [tws_pkg::TARGET_W-1:0]  i_target_id,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output tws_pkg::t_cmd                 o_q_cmd
);
    import tws_pkg::*;

    localparam int                 PROD_W   = 2 * FIELD_W;
    localparam logic [FIELD_W-1:0] W_F      = FIELD_W'(WHEEL_SLOTS);
    localparam logic [FIELD_W-1:0] RECIP    = FIELD_W'((1 << FIELD_W) / WHEEL_SLOTS);
    localparam logic [TICK_W-1:0]  W_RELOAD = TICK_W'(WHEEL_SLOTS - 1);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUB, F_PUSH} t_fstate;

    t_fstate              r_state;
    logic [FIELD_W-1:0]   r_dly;
    logic [FIELD_W-1:0]   r_per;
    logic [FIELD_W-1:0]   r_qd;
    logic [FIELD_W-1:0]   r_qp;
    logic                 r_periodic;
    logic [TARGET_W-1:0]  r_target;

    logic                 accept;
    logic [PROD_W-1:0]    dly_prod;
    logic [PROD_W-1:0]    per_prod;
    logic [PROD_W-1:0]    dly_back;
    logic [PROD_W-1:0]    per_back;
    logic [FIELD_W-1:0]   dly_fix;
    logic [FIELD_W-1:0]   per_fix;
    logic [TICK_W-1:0]    per_mod;
    t_cmd                 add_cmd;
    t_cmd                 pass_cmd;

    assign o_in_ready = (r_state == F_IDLE) && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Estimate quotients by reciprocal; the estimate is low by at most one
    assign dly_prod = PROD_W'(r_dly) * PROD_W'(RECIP);
    assign per_prod = PROD_W'(r_per) * PROD_W'(RECIP);
    assign dly_back = PROD_W'(r_qd) * PROD_W'(W_F);
    assign per_back = PROD_W'(r_qp) * PROD_W'(W_F);

    // Fold a remainder left one wheel too high
    assign dly_fix = (r_dly >= W_F) ? r_dly - W_F : r_dly;
    assign per_fix = (r_per >= W_F) ? r_per - W_F : r_per;

    // Build the add command from the reduced values
    assign per_mod = per_fix[TICK_W-1:0];
    always_comb begin
        add_cmd.op        = OP_ADD;
        add_cmd.delay_mod = dly_fix[TICK_W-1:0];
        add_cmd.reload    = (per_mod == '0) ? W_RELOAD : per_mod - 1'b1;
        add_cmd.periodic  = r_periodic;
        add_cmd.target    = r_target;
    end

    // Other ops go straight to the queue
    always_comb begin
        pass_cmd.op        = t_op'(i_op);
        pass_cmd.delay_mod = '0;
        pass_cmd.reload    = '0;
        pass_cmd.periodic  = 1'b0;
        pass_cmd.target    = i_target_id;
    end

    assign o_q_push = (accept && (t_op'(i_op) != OP_ADD)) ||
                      ((r_state == F_PUSH) && !i_q_full);
    assign o_q_cmd  = (r_state == F_PUSH) ? add_cmd : pass_cmd;

    // Sequence the modulo steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept && (t_op'(i_op) == OP_ADD)) begin
                        r_dly      <= i_first_delay;
                        r_per      <= i_repeat_period;
                        r_periodic <= (i_repeat_period != '0);
                        r_target   <= i_target_id;
                        r_state    <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_qd    <= dly_prod[PROD_W-1:FIELD_W];
                    r_qp    <= per_prod[PROD_W-1:FIELD_W];
                    r_state <= F_SUB;
                end
                F_SUB: begin
                    r_dly   <= r_dly - dly_back[FIELD_W-1:0];
                    r_per   <= r_per - per_back[FIELD_W-1:0];
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/tws_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on tws_pkg for the command type and depth.
module tws_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tws_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output tws_pkg::t_cmd o_cmd,
    output logic          o_valid
);
    import tws_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == DEPTH_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store items
    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr] <= i_cmd;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/tws_back.sv
// Back end: task table, tick and dispatch walks, result register.
// Depends on tws_pkg; takes commands from tws_queue.
module tws_back #(
    parameter int MAX_ENTRIES = tws_pkg::DEF_MAX_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  tws_pkg::t_cmd            i_cmd,
    output logic                     o_cmd_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [tws_pkg::ID_W-1:0] o_task_id,
    output logic [1:0]               o_status,
    output logic [tws_pkg::MS_W-1:0] o_elapsed_ms,
    output logic                     o_last
);
    import tws_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0]    N_CNT    = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0]    N_LAST   = CNT_W'(MAX_ENTRIES - 1);
    localparam logic [TARGET_W-1:0] N_TARGET = TARGET_W'(MAX_ENTRIES);
    localparam logic [EMIT_W-1:0]   EMIT_END = EMIT_W'(RESULT_CAP - 1);

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_SCAN, S_RESP} t_bstate;

    // Task table: valid and ready bits in flops, rows in memory
    t_entry                r_mem [MAX_ENTRIES];
    t_entry                r_rd;
    logic [MAX_ENTRIES-1:0] r_active;
    logic [MAX_ENTRIES-1:0] r_ready;
    logic [MS_W-1:0]       r_ms;

    t_bstate               r_state;
    t_cmd                  r_cmd;
    logic [CNT_W-1:0]      r_scan;
    logic                  r_b_vld;
    logic [IDX_W-1:0]      r_b_idx;
    logic [EMIT_W-1:0]     r_emit;
    logic [ID_W-1:0]       r_res_id;
    t_status               r_res_st;

    logic                  r_out_vld;
    logic [ID_W-1:0]       r_out_id;
    t_status               r_out_st;
    logic [MS_W-1:0]       r_out_ms;
    logic                  r_out_last;

    // Next values
    t_bstate               n_state;
    t_cmd                  n_cmd;
    logic [CNT_W-1:0]      n_scan;
    logic                  n_b_vld;
    logic [IDX_W-1:0]      n_b_idx;
    logic [EMIT_W-1:0]     n_emit;
    logic [ID_W-1:0]       n_res_id;
    t_status               n_res_st;
    logic [MAX_ENTRIES-1:0] n_active;
    logic [MAX_ENTRIES-1:0] n_ready;
    logic [MS_W-1:0]       n_ms;

    logic                  push;
    logic [ID_W-1:0]       push_id;
    t_status               push_st;
    logic                  push_last;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    t_entry                mem_wd;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_ra;

    logic                  out_free;
    logic                  scan_more;
    logic                  any_above;
    logic                  disp_push;
    logic                  disp_last;
    logic                  stall;
    logic [IDX_W-1:0]      add_idx;
    logic [IDX_W-1:0]      del_idx;
    logic [IDX_W+ID_W-1:0] add_ext;
    logic [IDX_W+ID_W-1:0] b_ext;

    assign out_free  = !r_out_vld || i_out_ready;
    assign scan_more = (r_scan != N_CNT);
    assign add_idx   = r_scan[IDX_W-1:0];
    assign del_idx   = r_cmd.target[IDX_W-1:0];
    assign add_ext   = {{ID_W{1'b0}}, add_idx};
    assign b_ext     = {{ID_W{1'b0}}, r_b_idx};

    // Look for ready entries above the one under evaluation
    always_comb begin
        any_above = 1'b0;
        for (int e = 0; e < MAX_ENTRIES; e++) begin
            if (r_ready[e] && (e > int'(r_b_idx))) any_above = 1'b1;
        end
    end

    assign disp_push = (r_state == S_SCAN) && (r_cmd.op == OP_DISPATCH) &&
                       r_b_vld && r_ready[r_b_idx];
    assign disp_last = !any_above || (r_emit == EMIT_END);
    assign stall     = disp_push && !out_free;

    // Control and table updates
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_scan   = r_scan;
        n_b_vld  = r_b_vld;
        n_b_idx  = r_b_idx;
        n_emit   = r_emit;
        n_res_id = r_res_id;
        n_res_st = r_res_st;
        n_active = r_active;
        n_ready  = r_ready;
        n_ms     = r_ms;
        push      = 1'b0;
        push_id   = '0;
        push_st   = ST_OK;
        push_last = 1'b1;
        mem_we   = 1'b0;
        mem_wa   = r_b_idx;
        mem_wd   = r_rd;
        mem_re   = 1'b0;
        mem_ra   = r_scan[IDX_W-1:0];
        o_cmd_pop = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_scan    = '0;
                    n_b_vld   = 1'b0;
                    n_emit    = '0;
                    n_res_id  = '0;
                    n_res_st  = ST_OK;
                    unique case (i_cmd.op)
                        OP_ADD: n_state = S_ADD;
                        OP_DELETE: begin
                            n_state = S_RESP;
                            if (i_cmd.target >= N_TARGET) begin
                                n_res_st = ST_RANGE;
                            end else begin
                                n_res_id = i_cmd.target[ID_W-1:0];
                                n_active[i_cmd.target[IDX_W-1:0]] = 1'b0;
                                n_ready[i_cmd.target[IDX_W-1:0]]  = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            n_ms    = r_ms + MS_PER_TICK;
                            n_state = S_SCAN;
                        end
                        OP_DISPATCH: begin
                            if (r_ready != '0) begin
                                n_state = S_SCAN;
                            end else begin
                                n_res_st = ST_NONE;
                                n_state  = S_RESP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_ADD: begin
                // Take the lowest free entry
                if (!r_active[add_idx]) begin
                    mem_we          = 1'b1;
                    mem_wa          = add_idx;
                    mem_wd.remain   = r_cmd.delay_mod;
                    mem_wd.reload   = r_cmd.reload;
                    mem_wd.periodic = r_cmd.periodic;
                    mem_wd.runs     = '0;
                    n_active[add_idx] = 1'b1;
                    n_ready[add_idx]  = 1'b0;
                    n_res_id = add_ext[ID_W-1:0];
                    n_res_st = ST_OK;
                    n_state  = S_RESP;
                end else if (r_scan == N_LAST) begin
                    n_res_st = ST_NONE;
                    n_state  = S_RESP;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end

            S_SCAN: begin
                if (!stall) begin
                    // Evaluate the row last read into r_rd
                    if (r_b_vld) begin
                        if (r_cmd.op == OP_TICK) begin
                            if (r_active[r_b_idx]) begin
                                mem_we = 1'b1;
                                if (r_rd.remain == '0) begin
                                    n_ready[r_b_idx] = 1'b1;
                                    if (r_rd.periodic) begin
                                        if (r_rd.runs != RUN_MAX) mem_wd.runs = r_rd.runs + 1'b1;
                                        mem_wd.remain = r_rd.reload;
                                    end else if (r_rd.runs == '0) begin
                                        mem_wd.runs = RUN_W'(1);
                                    end
                                end else begin
                                    mem_wd.remain = r_rd.remain - 1'b1;
                                end
                            end
                        end else if (disp_push) begin
                            push      = 1'b1;
                            push_id   = b_ext[ID_W-1:0];
                            push_last = disp_last;
                            n_emit    = r_emit + 1'b1;
                            if (r_rd.periodic) begin
                                mem_we           = 1'b1;
                                mem_wd.runs      = r_rd.runs - 1'b1;
                                n_ready[r_b_idx] = (r_rd.runs != RUN_W'(1));
                            end else begin
                                n_active[r_b_idx] = 1'b0;
                                n_ready[r_b_idx]  = 1'b0;
                            end
                            if (disp_last) n_state = S_IDLE;
                        end
                    end
                    // Issue the next read
                    if (scan_more) begin
                        mem_re  = 1'b1;
                        n_b_vld = 1'b1;
                        n_b_idx = r_scan[IDX_W-1:0];
                        n_scan  = r_scan + 1'b1;
                    end else begin
                        n_b_vld = 1'b0;
                        if (!r_b_vld) begin
                            n_state  = (r_cmd.op == OP_TICK) ? S_RESP : S_IDLE;
                            n_res_id = '0;
                            n_res_st = ST_OK;
                        end
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    push    = 1'b1;
                    push_id = r_res_id;
                    push_st = r_res_st;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Table rows: write one, read one per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= r_mem[mem_ra];
    end

    // State, table bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_ready   <= '0;
            r_ms      <= '0;
            r_scan    <= '0;
            r_b_vld   <= 1'b0;
            r_emit    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_scan   <= n_scan;
            r_b_vld  <= n_b_vld;
            r_b_idx  <= n_b_idx;
            r_emit   <= n_emit;
            r_res_id <= n_res_id;
            r_res_st <= n_res_st;
            r_active <= n_active;
            r_ready  <= n_ready;
            r_ms     <= n_ms;
            if (push) begin
                r_out_vld  <= 1'b1;
                r_out_id   <= push_id;
                r_out_st   <= push_st;
                r_out_ms   <= r_ms;
                r_out_last <= push_last;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_task_id    = r_out_id;
    assign o_status     = r_out_st;
    assign o_elapsed_ms = r_out_ms;
    assign o_last       = r_out_last;

endmodule

FILE: rtl/core/timing_wheel_task_scheduler.sv
// Timing wheel task scheduler.
// Input channel (i_in_valid / o_in_ready) takes one item: op, first delay,
// repeat period and target id. Output channel (o_out_valid / i_out_ready)
// gives result items: task id, status, elapsed milliseconds and a last flag
// on the final result of each item.
// Add: the modulo unit of the front end steps through F_MUL, F_SUB and
// F_PUSH, then the back end walks the valid bits for the lowest free entry.
// Delete needs no walk. Tick walks the table one row per cycle through the
// single read port and write port of the row memory. Dispatch walks the
// rows the same way and gives a result for each ready entry that the walk
// reaches, holding the walk while a result waits untaken; with nothing
// ready, it gives a single result with no walk.
// A two-entry command queue lets the front accept further items while the
// back is busy or a result waits in the output register.
// Reset clears the valid and ready bits of every entry and the millisecond
// counter; rows are rewritten on add, so no clearing pass is needed.
// When the receiver stalls, the back end holds its walk and the result
// register keeps its payload until taken.
// Depends on tws_pkg, tws_front, tws_queue and tws_back.
module timing_wheel_task_scheduler #(
    parameter int MAX_ENTRIES = tws_pkg::DEF_MAX_ENTRIES,
    parameter int WHEEL_SLOTS = tws_pkg::DEF_WHEEL_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [tws_pkg::FIELD_W-1:0]  i_first_delay,
    input  logic [tws_pkg::FIELD_W-1:0]  i_repeat_period,
    input  logic [tws_pkg::TARGET_W-1:0] i_target_id,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tws_pkg::ID_W-1:0]     o_task_id,
    output logic [1:0]                   o_status,
    output logic [tws_pkg::MS_W-1:0]     o_elapsed_ms,
    output logic                         o_last
);
    import tws_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_pop;
    t_cmd q_out_cmd;
    logic q_valid;

    tws_front #(
        .WHEEL_SLOTS(WHEEL_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_first_delay  (i_first_delay),
        .i_repeat_period(i_repeat_period),
        .i_target_id    (i_target_id),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    tws_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_cmd  (q_out_cmd),
        .o_valid(q_valid)
    );

    tws_back #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_task_id   (o_task_id),
        .o_status    (o_status),
        .o_elapsed_ms(o_elapsed_ms),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/core/tws_checker.sv
// Port-level checks of the timing wheel task scheduler, bound to the top level.
// Depends on tws_pkg for status codes.
module tws_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [tws_pkg::ID_W-1:0]     o_task_id,
    input logic [1:0]                   o_status,
    input logic [tws_pkg::MS_W-1:0]     o_elapsed_ms,
    input logic                         o_last
);
    import tws_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_task_id) &&
        $stable(o_status) && $stable(o_elapsed_ms) && $stable(o_last))
        else $error("result changed while stalled");

    // Drop any result during reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Error and empty results stand alone with id zero
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_last && (o_task_id == '0))
        else $error("error result not final or nonzero id");

    // Results inside a dispatch burst are ok
    a_burst_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == ST_OK)
        else $error("non-final result with error status");

endmodule

bind timing_wheel_task_scheduler tws_checker u_tws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_task_id   (o_task_id),
    .o_status    (o_status),
    .o_elapsed_ms(o_elapsed_ms),
    .o_last      (o_last)
);
